// File: design/lhwg_pkg.sv
`default_nettype none
package lhwg_pkg;

   localparam int WAVE_LAT = 18;
   localparam int Q_DEPTH  = 4;
   localparam int Q_AW     = 2;
   localparam int CSR_AW   = 3;

   localparam logic [2:0] FN_CONST = 3'd0;
   localparam logic [2:0] FN_RAMP  = 3'd1;
   localparam logic [2:0] FN_TRI   = 3'd2;
   localparam logic [2:0] FN_PULSE = 3'd3;

   localparam logic [CSR_AW-1:0] REG_X_HUE    = 3'd0;
   localparam logic [CSR_AW-1:0] REG_X_SAT    = 3'd1;
   localparam logic [CSR_AW-1:0] REG_X_VAL    = 3'd2;
   localparam logic [CSR_AW-1:0] REG_Y_HUE    = 3'd3;
   localparam logic [CSR_AW-1:0] REG_Y_SAT    = 3'd4;
   localparam logic [CSR_AW-1:0] REG_Y_VAL    = 3'd5;
   localparam logic [CSR_AW-1:0] REG_FALLBACK = 3'd6;
   localparam logic [CSR_AW-1:0] REG_ENTRY    = 3'd7;

   typedef struct packed {
      logic [26:0] x_hue;
      logic [26:0] x_sat;
      logic [26:0] x_val;
      logic [26:0] y_hue;
      logic [26:0] y_sat;
      logic [26:0] y_val;
      logic [7:0]  fallback;
      logic [31:0] entry_time;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  head_hue;
      logic [7:0]  head_sat;
      logic [7:0]  head_val;
      logic [31:0] pixel_mask;
      logic        use_mask;
      logic [7:0]  rep_hue;
      logic [7:0]  rep_sat;
      logic [7:0]  rep_val;
   } frame_type;

   typedef struct packed {
      logic [7:0]  rem;
      logic [15:0] qn;
      logic [7:0]  dvs;
      logic        neg;
      logic        lowm;
   } div_type;

   // one restoring division step: remainder, shifted dividend/quotient
   function automatic logic [23:0] div_step(input logic [7:0] rem, input logic [15:0] qn,
                                            input logic [7:0] dvs);
      logic [8:0] r2;
      logic [8:0] d;
      logic       ge;
      r2 = {rem, qn[15]};
      ge = (r2 >= {1'b0, dvs});
      d  = ge ? (r2 - {1'b0, dvs}) : r2;
      return {d[7:0], qn[14:0], ge};
   endfunction

endpackage
`default_nettype wire

// File: design/lhwg_wave.sv
`default_nettype none
module lhwg_wave
   import lhwg_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        ce,
   input  wire logic [26:0] wave,
   input  wire logic [7:0]  fallback,
   input  wire logic [15:0] t_in,
   output logic      [7:0]  result
);
   logic [2:0] func;
   logic [7:0] r, l, p, h;
   assign func = wave[26:24];
   assign r    = wave[23:16];
   assign l    = wave[15:8];
   assign p    = wave[7:0];
   assign h    = {1'b0, r[7:1]};

   // t mod r, two bits per stage
   logic [7:0]  mod_rem_ff [8];
   logic [15:0] mod_qn_ff  [8];
   logic [7:0]  mod_rem_in [8];
   logic [15:0] mod_qn_in  [8];

   for (genvar k = 0; k < 8; k++) begin : g_mod
      logic [23:0] s1, s2;
      always_comb begin
         if (k == 0) s1 = div_step(8'd0, t_in, r);
         else        s1 = div_step(mod_rem_ff[(k == 0) ? 0 : k - 1],
                                   mod_qn_ff[(k == 0) ? 0 : k - 1], r);
         s2 = div_step(s1[23:16], s1[15:0], r);
         mod_rem_in[k] = s2[23:16];
         mod_qn_in[k]  = s2[15:0];
      end
      always_ff @(posedge clock) begin
         if (ce) begin
            mod_rem_ff[k] <= mod_rem_in[k];
            mod_qn_ff[k]  <= mod_qn_in[k];
         end
      end
   end

   // numerator and divisor per function
   div_type num_in, num_ff;
   always_comb begin
      logic [7:0] m, diff, dst, dd;
      m    = mod_rem_ff[7];
      diff = (p >= l) ? (p - l) : (l - p);
      dst  = (m >= h) ? (m - h) : (h - m);
      dd   = p - l;
      num_in      = '0;
      num_in.lowm = (m < p);
      unique case (func)
         FN_RAMP: begin
            num_in.qn  = m * diff;
            num_in.dvs = r;
            num_in.neg = (p < l);
         end
         FN_TRI: begin
            num_in.qn  = dst * dd;
            num_in.dvs = h;
         end
         FN_PULSE: begin
            num_in.qn  = {5'd0, 8'(m - p), 3'd0};
            num_in.dvs = r;
         end
         default: begin
            num_in.qn  = '0;
            num_in.dvs = r;
         end
      endcase
   end
   always_ff @(posedge clock) begin
      if (ce) num_ff <= num_in;
   end

   // quotient, two bits per stage
   div_type div_ff [8];
   div_type div_in [8];
   for (genvar k = 0; k < 8; k++) begin : g_div
      always_comb begin
         div_type     src;
         logic [23:0] s1, s2;
         src = (k == 0) ? num_ff : div_ff[(k == 0) ? 0 : k - 1];
         s1 = div_step(src.rem, src.qn, src.dvs);
         s2 = div_step(s1[23:16], s1[15:0], src.dvs);
         div_in[k]     = src;
         div_in[k].rem = s2[23:16];
         div_in[k].qn  = s2[15:0];
      end
      always_ff @(posedge clock) begin
         if (ce) div_ff[k] <= div_in[k];
      end
   end

   logic [7:0] res_in, res_ff;
   always_comb begin
      logic [15:0] q;
      logic [16:0] o;
      q = div_ff[7].qn;
      o = {9'd0, l} + {1'b0, q};
      unique case (func)
         FN_CONST: res_in = p;
         FN_RAMP: begin
            if (r == 8'd0)         res_in = fallback;
            else if (div_ff[7].neg) res_in = l - q[7:0];
            else                    res_in = l + q[7:0];
         end
         FN_TRI: begin
            if (h == 8'd0)        res_in = fallback;
            else if (o > 17'd255) res_in = 8'hff;
            else                  res_in = o[7:0];
         end
         FN_PULSE: begin
            if (r == 8'd0)          res_in = fallback;
            else if (div_ff[7].lowm) res_in = 8'hff;
            else if (q >= 16'd8)    res_in = 8'd0;
            else                    res_in = 8'hff >> q[2:0];
         end
         default: res_in = fallback;
      endcase
   end
   always_ff @(posedge clock) begin
      if (ce) res_ff <= res_in;
   end
   assign result = res_ff;
endmodule
`default_nettype wire

// File: design/lhwg_queue.sv
`default_nettype none
module lhwg_queue
   import lhwg_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire frame_type push_data,
   input  wire logic      pop,
   output frame_type      head,
   output logic           not_empty,
   output logic [Q_AW:0]  count
);
   frame_type         mem_ff [Q_DEPTH];
   logic [Q_AW-1:0]   wr_ff, rd_ff;
   logic [Q_AW:0]     cnt_ff;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
      end
   end

   assign head      = mem_ff[rd_ff];
   assign not_empty = (cnt_ff != '0);
   assign count     = cnt_ff;
endmodule
`default_nettype wire

// File: design/lhwg_front.sv
`default_nettype none
module lhwg_front
   import lhwg_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cfg_type       cfg,
   input  wire logic          in_valid,
   output logic               in_ready,
   input  wire logic [31:0]   now_ms,
   input  wire logic [31:0]   last_low_ms,
   input  wire logic          restart,
   input  wire logic [31:0]   pixel_mask,
   input  wire logic          use_mask,
   input  wire logic [23:0]   replace_color,
   input  wire logic [Q_AW:0] q_count,
   output logic               push,
   output frame_type          push_data
);
   logic        accept;
   logic [15:0] t_idx;
   logic [7:0]  hh, hs, hv;

   // credits: frames in flight plus queued never exceed the queue depth
   logic [Q_AW:0]   infl_ff, infl_in;
   logic [Q_AW+1:0] used;
   assign used     = {1'b0, infl_ff} + {1'b0, q_count};
   assign in_ready = (used < (Q_AW+2)'(Q_DEPTH));
   assign accept   = in_valid && in_ready;

   assign t_idx = restart ? (now_ms[15:0] - last_low_ms[15:0])
                          : (now_ms[15:0] - cfg.entry_time[15:0]);

   lhwg_wave u_hue (.clock, .ce(1'b1), .wave(cfg.x_hue), .fallback(cfg.fallback),
                    .t_in(t_idx), .result(hh));
   lhwg_wave u_sat (.clock, .ce(1'b1), .wave(cfg.x_sat), .fallback(cfg.fallback),
                    .t_in(t_idx), .result(hs));
   lhwg_wave u_val (.clock, .ce(1'b1), .wave(cfg.x_val), .fallback(cfg.fallback),
                    .t_in(t_idx), .result(hv));

   logic      vld_ff  [WAVE_LAT];
   frame_type side_ff [WAVE_LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < WAVE_LAT; k++) vld_ff[k] <= 1'b0;
         infl_ff <= '0;
      end else begin
         vld_ff[0] <= accept;
         for (int k = 1; k < WAVE_LAT; k++) vld_ff[k] <= vld_ff[k-1];
         infl_ff <= infl_in;
      end
   end
   assign infl_in = infl_ff + (Q_AW+1)'(accept) - (Q_AW+1)'(vld_ff[WAVE_LAT-1]);

   always_ff @(posedge clock) begin
      side_ff[0].head_hue   <= '0;
      side_ff[0].head_sat   <= '0;
      side_ff[0].head_val   <= '0;
      side_ff[0].pixel_mask <= pixel_mask;
      side_ff[0].use_mask   <= use_mask;
      side_ff[0].rep_hue    <= replace_color[7:0];
      side_ff[0].rep_sat    <= replace_color[15:8];
      side_ff[0].rep_val    <= replace_color[23:16];
      for (int k = 1; k < WAVE_LAT; k++) side_ff[k] <= side_ff[k-1];
   end

   always_comb begin
      push_data          = side_ff[WAVE_LAT-1];
      push_data.head_hue = hh;
      push_data.head_sat = hs;
      push_data.head_val = hv;
   end
   assign push = vld_ff[WAVE_LAT-1];
endmodule
`default_nettype wire

// File: design/lhwg_back.sv
`default_nettype none
module lhwg_back
   import lhwg_pkg::*;
#(
   parameter int NUM_PIXELS = 32
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire cfg_type   cfg,
   input  wire frame_type head,
   input  wire logic      not_empty,
   output logic           pop,
   output logic           out_valid,
   input  wire logic      out_ready,
   output logic [4:0]     pixel_index,
   output logic [7:0]     hue,
   output logic [7:0]     sat,
   output logic [7:0]     val,
   output logic           last
);
   typedef struct packed {
      logic [4:0] pixel;
      logic       last;
      logic       sel_rep;
      logic [7:0] rep_hue;
      logic [7:0] rep_sat;
      logic [7:0] rep_val;
      logic [7:0] head_hue;
      logic [7:0] head_sat;
      logic [7:0] head_val;
   } pix_type;

   logic       ce, issue, pix_last;
   logic [4:0] pix_ff, pix_in;
   logic [7:0] yh, ys, yv;
   logic       out_valid_ff;

   assign ce       = !out_valid_ff || out_ready;
   assign issue    = ce && not_empty;
   assign pix_last = (pix_ff == 5'(NUM_PIXELS - 1));
   assign pop      = issue && pix_last;
   assign pix_in   = pix_last ? 5'd0 : pix_ff + 5'd1;

   lhwg_wave u_hue (.clock, .ce, .wave(cfg.y_hue), .fallback(cfg.fallback),
                    .t_in({11'd0, pix_ff}), .result(yh));
   lhwg_wave u_sat (.clock, .ce, .wave(cfg.y_sat), .fallback(cfg.fallback),
                    .t_in({11'd0, pix_ff}), .result(ys));
   lhwg_wave u_val (.clock, .ce, .wave(cfg.y_val), .fallback(cfg.fallback),
                    .t_in({11'd0, pix_ff}), .result(yv));

   logic    vld_ff  [WAVE_LAT];
   pix_type side_ff [WAVE_LAT];
   pix_type side_in;

   always_comb begin
      side_in.pixel    = pix_ff;
      side_in.last     = pix_last;
      side_in.sel_rep  = head.use_mask && !head.pixel_mask[pix_ff];
      side_in.rep_hue  = head.rep_hue;
      side_in.rep_sat  = head.rep_sat;
      side_in.rep_val  = head.rep_val;
      side_in.head_hue = head.head_hue;
      side_in.head_sat = head.head_sat;
      side_in.head_val = head.head_val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_ff       <= '0;
         out_valid_ff <= 1'b0;
         for (int k = 0; k < WAVE_LAT; k++) vld_ff[k] <= 1'b0;
      end else if (ce) begin
         if (issue) pix_ff <= pix_in;
         vld_ff[0] <= issue;
         for (int k = 1; k < WAVE_LAT; k++) vld_ff[k] <= vld_ff[k-1];
         out_valid_ff <= vld_ff[WAVE_LAT-1];
      end
   end

   logic [4:0] idx_ff;
   logic [7:0] hue_ff, sat_ff, val_ff;
   logic       last_ff;
   pix_type    tail;
   assign tail = side_ff[WAVE_LAT-1];

   always_ff @(posedge clock) begin
      if (ce) begin
         side_ff[0] <= side_in;
         for (int k = 1; k < WAVE_LAT; k++) side_ff[k] <= side_ff[k-1];
         idx_ff  <= tail.pixel;
         last_ff <= tail.last;
         hue_ff  <= tail.sel_rep ? tail.rep_hue : tail.head_hue + yh;
         sat_ff  <= tail.sel_rep ? tail.rep_sat : tail.head_sat + ys;
         val_ff  <= tail.sel_rep ? tail.rep_val : tail.head_val + yv;
      end
   end

   assign out_valid   = out_valid_ff;
   assign pixel_index = idx_ff;
   assign hue         = hue_ff;
   assign sat         = sat_ff;
   assign val         = val_ff;
   assign last        = last_ff;
endmodule
`default_nettype wire

// File: design/led_hsv_waveform_frame_generator.sv
// rsp_tvalid for the first pixel of a frame rises after the request transfer passes the
// 18-stage time waveform pipe, queue, 18-stage pixel waveform pipe and output reg.
// Throughput: one pixel per cycle, set by the pixel pipe, which stalls on rsp_tready low.
// At most four frames sit in the time pipe and the queue together.
// Reset (synchronous, active high) clears the config registers to 0 and empties the pipes.
`default_nettype none
module led_hsv_waveform_frame_generator
   import lhwg_pkg::*;
#(
   parameter int NUM_PIXELS = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   // now_ms, last_low_ms, pixel_mask, replace_hue, replace_sat, replace_val
   input  wire logic [119:0]      req_tdata,
   // restart, use_mask
   input  wire logic [1:0]        req_tuser,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   // pixel_index, hue, sat, val, zero pad
   output logic [31:0]            rsp_tdata,
   output logic                   rsp_tlast,
   input  wire logic              csr_we,
   input  wire logic [CSR_AW-1:0] csr_index,
   input  wire logic [31:0]       csr_wdata
);
   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_X_HUE:    cfg_ff.x_hue      <= csr_wdata[26:0];
            REG_X_SAT:    cfg_ff.x_sat      <= csr_wdata[26:0];
            REG_X_VAL:    cfg_ff.x_val      <= csr_wdata[26:0];
            REG_Y_HUE:    cfg_ff.y_hue      <= csr_wdata[26:0];
            REG_Y_SAT:    cfg_ff.y_sat      <= csr_wdata[26:0];
            REG_Y_VAL:    cfg_ff.y_val      <= csr_wdata[26:0];
            REG_FALLBACK: cfg_ff.fallback   <= csr_wdata[7:0];
            REG_ENTRY:    cfg_ff.entry_time <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic          push, pop, not_empty;
   frame_type     push_data, head;
   logic [Q_AW:0] q_count;

   lhwg_front u_front (
      .clock, .reset, .cfg(cfg_ff),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .now_ms(req_tdata[31:0]), .last_low_ms(req_tdata[63:32]),
      .restart(req_tuser[0]), .pixel_mask(req_tdata[95:64]),
      .use_mask(req_tuser[1]), .replace_color(req_tdata[119:96]),
      .q_count, .push, .push_data
   );

   lhwg_queue u_queue (
      .clock, .reset, .push, .push_data, .pop, .head, .not_empty, .count(q_count)
   );

   logic [4:0] pix;
   logic [7:0] hue, sat, val;

   lhwg_back #(.NUM_PIXELS(NUM_PIXELS)) u_back (
      .clock, .reset, .cfg(cfg_ff), .head, .not_empty, .pop,
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .pixel_index(pix), .hue, .sat, .val, .last(rsp_tlast)
   );

   assign rsp_tdata = {3'd0, val, sat, hue, pix};

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (q_count < (Q_AW+1)'(Q_DEPTH) || pop))
      else $error("frame queue overflow");

   a_last_pixel: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (pix == 5'(NUM_PIXELS - 1))))
      else $error("tlast does not match final pixel");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from empty frame queue");
endmodule
`default_nettype wire

// File: sim/tb_led_hsv_waveform_frame_generator.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_led_hsv_waveform_frame_generator
   import lhwg_pkg::*;
();

   localparam int NPIX = 32;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [31:0] now_ms;
      logic [31:0] last_low_ms;
      logic        restart;
      logic [31:0] pixel_mask;
      logic        use_mask;
      logic [7:0]  rep_hue;
      logic [7:0]  rep_sat;
      logic [7:0]  rep_val;
   } frame_req_type;

   typedef struct packed {
      logic [4:0] pix;
      logic [7:0] hue;
      logic [7:0] sat;
      logic [7:0] val;
      logic       last;
   } pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [119:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_we = 1'b0;
   logic [CSR_AW-1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   led_hsv_waveform_frame_generator #(.NUM_PIXELS(NPIX)) u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // shadow copy of the register file
   logic [26:0] wave_reg [6];
   logic [7:0]  fallback_reg;
   logic [31:0] entry_reg;

   pixel_type pending_pixels[$];
   int mismatches = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_cycles = 0;
   int quiet_cycles = 0;

   function automatic logic [7:0] wave_value(logic [26:0] w, logic [15:0] t);
      logic [2:0] fn;
      int unsigned r, l, p, m, h, d, dst, o, sh;
      int sv;
      fn = w[26:24];
      r = w[23:16];
      l = w[15:8];
      p = w[7:0];
      case (fn)
         FN_CONST: return p[7:0];
         FN_RAMP: begin
            if (r == 0) return fallback_reg;
            m = t % r;
            sv = int'(l) + (int'(m) * (int'(p) - int'(l))) / int'(r);
            return sv[7:0];
         end
         FN_TRI: begin
            h = r / 2;
            if (h == 0) return fallback_reg;
            d = (p - l) & 8'hff;
            m = t % r;
            dst = (m >= h) ? m - h : h - m;
            o = l + dst * d / h;
            return (o > 255) ? 8'hff : o[7:0];
         end
         FN_PULSE: begin
            if (r == 0) return fallback_reg;
            m = t % r;
            if (m < p) return 8'hff;
            sh = (m - p) * 8 / r;
            if (sh >= 8) return 8'h00;
            return 8'hff >> sh;
         end
         default: return fallback_reg;
      endcase
   endfunction

   function automatic void predict_frame(frame_req_type f);
      logic [31:0] diff;
      logic [7:0] hh, hs, hv;
      pixel_type px;
      diff = f.restart ? f.now_ms - f.last_low_ms : f.now_ms - entry_reg;
      hh = wave_value(wave_reg[0], diff[15:0]);
      hs = wave_value(wave_reg[1], diff[15:0]);
      hv = wave_value(wave_reg[2], diff[15:0]);
      for (int i = 0; i < NPIX; i++) begin
         px.pix = i[4:0];
         px.last = (i == NPIX - 1);
         if (f.use_mask && !f.pixel_mask[i]) begin
            px.hue = f.rep_hue; px.sat = f.rep_sat; px.val = f.rep_val;
         end else begin
            px.hue = hh + wave_value(wave_reg[3], i[15:0]);
            px.sat = hs + wave_value(wave_reg[4], i[15:0]);
            px.val = hv + wave_value(wave_reg[5], i[15:0]);
         end
         pending_pixels.push_back(px);
      end
   endfunction

   // receiver side: ready pattern and checking
   always @(posedge clock) begin
      pixel_type got, want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[4:0], rsp_tdata[12:5], rsp_tdata[20:13], rsp_tdata[28:21],
                   rsp_tlast};
            if (pending_pixels.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected pixel transfer %h", got);
            end else begin
               want = pending_pixels.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch exp %0d %h %h %h %b got %0d %h %h %h %b",
                              want.pix, want.hue, want.sat, want.val, want.last,
                              got.pix, got.hue, got.sat, got.val, got.last);
               end
            end
         end
         if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic write_csr(logic [CSR_AW-1:0] idx, logic [31:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == REG_FALLBACK) fallback_reg = data[7:0];
      else if (idx == REG_ENTRY) entry_reg = data;
      else wave_reg[idx] = data[26:0];
      @(posedge clock);
   endtask

   // tvalid stays high after a transfer until the next frame or drain() replaces it
   task automatic send_frame(frame_req_type f);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {f.rep_val, f.rep_sat, f.rep_hue, f.pixel_mask, f.last_low_ms, f.now_ms};
      req_tuser <= {f.use_mask, f.restart};
      do @(posedge clock); while (!req_tready);
      predict_frame(f);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   function automatic logic [26:0] rand_wave();
      logic [26:0] w;
      w = 27'($urandom);
      // mostly valid functions; small ranges stress wraparound
      if ($urandom_range(9) < 8) w[26:24] = 3'($urandom_range(3));
      if ($urandom_range(3) == 0) w[23:16] = 8'($urandom_range(3));
      return w;
   endfunction

   function automatic frame_req_type rand_frame();
      frame_req_type f;
      f.now_ms = $urandom;
      f.last_low_ms = ($urandom_range(1)) ? f.now_ms - $urandom_range(2000) : $urandom;
      f.restart = 1'($urandom_range(1));
      f.pixel_mask = $urandom;
      f.use_mask = 1'($urandom_range(1));
      f.rep_hue = 8'($urandom); f.rep_sat = 8'($urandom); f.rep_val = 8'($urandom);
      return f;
   endfunction

   // directed: use_mask with all-clear mask gives replace colors everywhere
   typedef struct {
      frame_req_type f;
      logic fixed;
   } dir_row_type;

   initial begin
      dir_row_type rows[8];
      frame_req_type f;
      pixel_type px;
      for (int i = 0; i < 6; i++) wave_reg[i] = '0;
      fallback_reg = '0;
      entry_reg = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // after reset every pixel is 0 unless masked off
      rows[0] = '{'{32'h0, 32'h0, 1'b0, 32'h0, 1'b1, 8'hff, 8'h00, 8'haa}, 1'b1};
      rows[1] = '{'{32'hffffffff, 32'h0, 1'b1, 32'hffffffff, 1'b1, 8'h12, 8'h34, 8'h56}, 1'b1};
      rows[2] = '{'{32'h0, 32'hffffffff, 1'b1, 32'h0, 1'b0, 8'hff, 8'hff, 8'hff}, 1'b1};
      rows[3] = '{'{32'h12345678, 32'h1, 1'b1, 32'h55555555, 1'b1, 8'h00, 8'h00, 8'h00}, 1'b0};
      for (int k = 0; k < 4; k++) begin
         if (rows[k].fixed) begin
            send_idle_pct = 0;
            // known outcome: zero heading, mask decides replace color
            for (int i = 0; i < NPIX; i++) begin
               px.pix = i[4:0]; px.last = (i == NPIX - 1);
               if (rows[k].f.use_mask && !rows[k].f.pixel_mask[i])
                  {px.hue, px.sat, px.val} = {rows[k].f.rep_hue, rows[k].f.rep_sat,
                                              rows[k].f.rep_val};
               else {px.hue, px.sat, px.val} = '0;
               pending_pixels.push_back(px);
            end
            req_tvalid <= 1'b1;
            req_tdata <= {rows[k].f.rep_val, rows[k].f.rep_sat, rows[k].f.rep_hue,
                          rows[k].f.pixel_mask, rows[k].f.last_low_ms, rows[k].f.now_ms};
            req_tuser <= {rows[k].f.use_mask, rows[k].f.restart};
            do @(posedge clock); while (!req_tready);
         end else begin
            send_frame(rows[k].f);
         end
      end
      drain();

      // directed per function: const, ramp, tri (clamp), pulse (large shift), bad code, zero divisor
      write_csr(REG_FALLBACK, 32'h5a);
      write_csr(REG_ENTRY, 32'hfffffff0);
      write_csr(REG_X_HUE, {5'd0, FN_RAMP, 8'd7, 8'd10, 8'd250});
      write_csr(REG_X_SAT, {5'd0, FN_TRI, 8'd255, 8'd200, 8'd100});
      write_csr(REG_X_VAL, {5'd0, FN_PULSE, 8'd9, 8'd0, 8'd2});
      write_csr(REG_Y_HUE, {5'd0, FN_PULSE, 8'd255, 8'd77, 8'd0});
      write_csr(REG_Y_SAT, {5'd0, 3'd7, 8'd5, 8'd5, 8'd5});
      write_csr(REG_Y_VAL, {5'd0, FN_TRI, 8'd1, 8'd0, 8'd0});
      for (int k = 0; k < 8; k++) begin
         f = rand_frame();
         f.now_ms = k * 3;
         f.last_low_ms = 32'hffff0000 + k;
         f.restart = k[0];
         send_frame(f);
      end
      drain();
      write_csr(REG_X_HUE, {5'd0, FN_RAMP, 8'd0, 8'd1, 8'd1});
      write_csr(REG_X_SAT, {5'd0, FN_CONST, 8'hff, 8'hff, 8'hff});
      write_csr(REG_X_VAL, {5'd0, 3'd4, 8'd0, 8'd0, 8'd0});
      write_csr(REG_Y_HUE, {5'd0, FN_RAMP, 8'd255, 8'd255, 8'd0});
      write_csr(REG_Y_SAT, {5'd0, FN_PULSE, 8'd0, 8'd0, 8'd0});
      write_csr(REG_Y_VAL, {5'd0, FN_PULSE, 8'd3, 8'd0, 8'd0});
      write_csr(REG_FALLBACK, 32'hff);
      for (int k = 0; k < 6; k++) send_frame(rand_frame());
      drain();

      // random phases with fresh register settings
      for (int phase = 0; phase < 6; phase++) begin
         for (int r = 0; r < 6; r++) write_csr(r[CSR_AW-1:0], {5'd0, rand_wave()});
         write_csr(REG_FALLBACK, $urandom);
         write_csr(REG_ENTRY, $urandom);
         case (phase)
            0, 1: begin send_idle_pct = 31; recv_idle_pct = 74; end
            2, 3: begin send_idle_pct = 74; recv_idle_pct = 31; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         if (phase == 4) hold_cycles <= 600;
         for (int k = 0; k < 52; k++) send_frame(rand_frame());
         drain();
      end

      if (mismatches == 0 && pending_pixels.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire
